FILE: rtl/core/mrd_pkg.sv
// Shared types and constants for the motor reply decoder.
package mrd_pkg;

	localparam int FRAME_ID_W = 11;
	localparam int PAYLOAD_W = 64;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 240;
	localparam int OUT_FIELDS_W = 233;
	localparam int OUT_PAD_W = M_TDATA_W - OUT_FIELDS_W;

	localparam int ENC_W = 16;
	localparam int TURNS_W = 32;
	localparam int ACC_W = 48;
	localparam int STEP_W = 18;

	localparam int COUNTS_PER_TURN_DEF = 65536;
	localparam logic [FRAME_ID_W-1:0] OWN_FRAME_ID_RST = 11'd321;

	localparam logic [7:0] CMD_STATUS2 = 8'h9C;
	localparam logic [7:0] CMD_CLOSED_1 = 8'hA1;
	localparam logic [7:0] CMD_CLOSED_2 = 8'hA2;
	localparam logic [7:0] CMD_CLOSED_3 = 8'hA3;
	localparam logic [7:0] CMD_CLOSED_4 = 8'hA4;
	localparam logic [7:0] CMD_CLOSED_5 = 8'hA5;
	localparam logic [7:0] CMD_CLOSED_6 = 8'hA6;
	localparam logic [7:0] CMD_CLOSED_7 = 8'hA7;
	localparam logic [7:0] CMD_CLOSED_8 = 8'hA8;
	localparam logic [7:0] CMD_STATUS1_A = 8'h9A;
	localparam logic [7:0] CMD_STATUS1_B = 8'h9B;
	localparam logic [7:0] CMD_TOTAL_ANGLE = 8'h92;
	localparam logic [7:0] CMD_ACCEL_A = 8'h33;
	localparam logic [7:0] CMD_ACCEL_B = 8'h34;

	typedef struct packed {
		logic [PAYLOAD_W-1:0]  payload;
		logic [FRAME_ID_W-1:0] frame_id;
	} in_item_t;

	typedef struct packed {
		logic match;
		logic motion;
		logic status1;
		logic total_angle;
		logic accel;
	} upd_t;

	typedef struct packed {
		logic               started;
		logic [ENC_W-1:0]   last_position;
		logic [TURNS_W-1:0] turns;
		logic [ACC_W-1:0]   accumulator;
	} track_state_t;

endpackage

FILE: rtl/core/mrd_in_stage.sv
// Input register stage holding one request frame.
module mrd_in_stage
	import mrd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [S_TDATA_W-1:0] in_data,
	input  logic                 advance,
	output logic                 valid_s1,
	output in_item_t             item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item_t'(in_data[FRAME_ID_W+PAYLOAD_W-1:0]);
		end
	end

endmodule

FILE: rtl/core/mrd_decode.sv
// Identifier match and command dispatch for one reply frame.
module mrd_decode
	import mrd_pkg::*;
(
	input  logic [FRAME_ID_W-1:0] frame_id,
	input  logic [FRAME_ID_W-1:0] own_frame_id,
	input  logic [7:0]            command_code,
	output upd_t                  upd
);

	logic match;

	assign match = (frame_id == own_frame_id);

	always_comb begin
		upd = '0;
		upd.match = match;
		case (command_code)
			CMD_STATUS2, CMD_CLOSED_1, CMD_CLOSED_2, CMD_CLOSED_3, CMD_CLOSED_4,
			CMD_CLOSED_5, CMD_CLOSED_6, CMD_CLOSED_7, CMD_CLOSED_8: begin
				upd.motion = match;
			end
			CMD_STATUS1_A, CMD_STATUS1_B: begin
				upd.status1 = match;
			end
			CMD_TOTAL_ANGLE: begin
				upd.total_angle = match;
			end
			CMD_ACCEL_A, CMD_ACCEL_B: begin
				upd.accel = match;
			end
			default: begin
				upd.motion = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/core/mrd_turn_track.sv
// Multi-turn unwrapping of the encoder position.
module mrd_turn_track
	import mrd_pkg::*;
#(
	parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
	input  track_state_t     cur,
	input  logic [ENC_W-1:0] encoder,
	output track_state_t     nxt
);

	localparam int HALF_TURN = COUNTS_PER_TURN / 2;
	localparam logic signed [STEP_W-1:0] HALF_S = STEP_W'(HALF_TURN);
	localparam logic signed [STEP_W-1:0] TURN_S = STEP_W'(COUNTS_PER_TURN);

	logic signed [STEP_W-1:0] step_raw;
	logic signed [STEP_W-1:0] step;
	logic [TURNS_W-1:0]       turns_nxt;

	assign step_raw = $signed({{(STEP_W-ENC_W){encoder[ENC_W-1]}}, encoder})
		- $signed({{(STEP_W-ENC_W){cur.last_position[ENC_W-1]}}, cur.last_position});

	always_comb begin
		step = step_raw;
		turns_nxt = cur.turns;
		if (step_raw > HALF_S) begin
			step = step_raw - TURN_S;
			turns_nxt = cur.turns - TURNS_W'(1);
		end else if (step_raw < -HALF_S) begin
			step = step_raw + TURN_S;
			turns_nxt = cur.turns + TURNS_W'(1);
		end
	end

	always_comb begin
		nxt = cur;
		nxt.started = 1'b1;
		nxt.last_position = encoder;
		if (cur.started) begin
			nxt.turns = turns_nxt;
			nxt.accumulator = cur.accumulator
				+ {{(ACC_W-STEP_W){step[STEP_W-1]}}, step};
		end
	end

endmodule

FILE: rtl/core/mrd_state.sv
// Motor state registers, configuration register and result register.
module mrd_state
	import mrd_pkg::*;
#(
	parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [FRAME_ID_W-1:0] cfg_wr_data,
	output logic [FRAME_ID_W-1:0] own_frame_id,
	input  logic                  valid_s1,
	input  in_item_t              item_s1,
	input  upd_t                  upd,
	output logic                  advance,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [M_TDATA_W-1:0]  out_data
);

	logic [FRAME_ID_W-1:0] own_frame_id_q;
	logic                  out_valid_q;
	logic                  accepted_q;
	logic [7:0]            code_q;
	track_state_t          trk_q;
	track_state_t          trk_nxt;
	logic [7:0]            temp_q;
	logic [15:0]           current_q;
	logic [15:0]           speed_q;
	logic [15:0]           voltage_q;
	logic [7:0]            error_q;
	logic [31:0]           accel_q;
	logic [31:0]           total_reply_q;
	logic                  load;
	logic [63:0]           p;

	assign p = item_s1.payload;
	assign advance = !out_valid_q || out_ready;
	assign load = advance && valid_s1;
	assign own_frame_id = own_frame_id_q;
	assign out_valid = out_valid_q;

	mrd_turn_track #(
		.COUNTS_PER_TURN(COUNTS_PER_TURN)
	) u_turn_track (
		.cur    (trk_q),
		.encoder(p[63:48]),
		.nxt    (trk_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_frame_id_q <= OWN_FRAME_ID_RST;
		end else if (cfg_wr_en) begin
			own_frame_id_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			accepted_q <= upd.match;
			code_q <= p[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q <= '0;
			temp_q <= '0;
			current_q <= '0;
			speed_q <= '0;
			voltage_q <= '0;
			error_q <= '0;
			accel_q <= '0;
			total_reply_q <= '0;
		end else if (load) begin
			if (upd.motion) begin
				temp_q <= p[15:8];
				current_q <= p[31:16];
				speed_q <= p[47:32];
				trk_q <= trk_nxt;
			end
			if (upd.status1) begin
				temp_q <= p[15:8];
				voltage_q <= p[39:24];
				error_q <= p[63:56];
			end
			if (upd.total_angle) begin
				total_reply_q <= p[39:8];
			end
			if (upd.accel) begin
				accel_q <= p[63:32];
			end
		end
	end

	// The state registers only move when the result register loads, so they always
	// show the state after the request that is currently on the output.
	assign out_data = {
		{OUT_PAD_W{1'b0}},
		total_reply_q,
		accel_q,
		voltage_q,
		error_q,
		trk_q.accumulator,
		trk_q.turns,
		trk_q.last_position,
		speed_q,
		current_q,
		temp_q,
		code_q,
		accepted_q
	};

endmodule

FILE: rtl/core/motor_reply_decoder_multiturn.sv
// Top level of the motor reply decoder with multi-turn encoder tracking.
// A request accepted at the input passes through the input register and then the result register.
// Throughput: one request per cycle while the result register is not stalled by m_axis_tready,
// with the state update done between the input register and the result register.
// Reset clears all motor state and pipeline valids and loads the frame identifier 321.
module motor_reply_decoder_multiturn
	import mrd_pkg::*;
#(
	parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [FRAME_ID_W-1:0] cfg_wr_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// Fields from bit 0: frame_id[10:0], payload[74:11], zero fill.
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// Fields from bit 0: accepted, command_code, temperature, torque_current,
	// speed_raw, encoder_value, round_count, total_counts, error_flags,
	// bus_voltage, accel_value, reported_total_angle, zero fill.
	output logic [M_TDATA_W-1:0]  m_axis_tdata
);

	logic                  advance;
	logic                  valid_s1;
	in_item_t              item_s1;
	upd_t                  upd;
	logic [FRAME_ID_W-1:0] own_frame_id;

	mrd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_data (s_axis_tdata),
		.advance (advance),
		.valid_s1(valid_s1),
		.item_s1 (item_s1)
	);

	mrd_decode u_decode (
		.frame_id    (item_s1.frame_id),
		.own_frame_id(own_frame_id),
		.command_code(item_s1.payload[7:0]),
		.upd         (upd)
	);

	mrd_state #(
		.COUNTS_PER_TURN(COUNTS_PER_TURN)
	) u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.own_frame_id(own_frame_id),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.upd         (upd),
		.advance     (advance),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata)
	);

endmodule

FILE: rtl/core/mrd_checker.sv
// Port-level checker for the motor reply decoder, bound to the top level.
module mrd_checker
	import mrd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("Result valid dropped while stalled.");

	a_out_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("Result data changed while stalled.");

	a_result_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("Result appeared without a request two cycles earlier.");

	a_one_request_buffered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready
		|=> !s_axis_tready || m_axis_tready)
		else $error("More than one request taken behind a stalled result.");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("Input stalled while the result register can move.");

endmodule

bind motor_reply_decoder_multiturn mrd_checker u_mrd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

FILE: tb/motor_reply_compare.sv
`timescale 1ns / 100ps
// Reply predictor and field-by-field comparator for the motor reply decoder testbench.
module motor_reply_compare
	import mrd_pkg::*;
#(
	parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [FRAME_ID_W-1:0] cfg_wr_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [M_TDATA_W-1:0]  m_axis_tdata,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [31:0]          reported_total_angle;
		logic [31:0]          accel_value;
		logic [15:0]          bus_voltage;
		logic [7:0]           error_flags;
		logic [ACC_W-1:0]     total_counts;
		logic [TURNS_W-1:0]   round_count;
		logic [ENC_W-1:0]     encoder_value;
		logic [15:0]          speed_raw;
		logic [15:0]          torque_current;
		logic [7:0]           temperature;
		logic [7:0]           command_code;
		logic                 accepted;
	} motor_reply_t;

	logic [FRAME_ID_W-1:0] own_frame_id;
	logic                  tracking_on;
	logic [ENC_W-1:0]      prev_position;
	logic [TURNS_W-1:0]    turn_count;
	logic [ACC_W-1:0]      angle_counts;
	logic [7:0]            temp_q;
	logic [7:0]            error_q;
	logic [15:0]           current_q;
	logic [15:0]           speed_q;
	logic [15:0]           voltage_q;
	logic [31:0]           accel_q;
	logic [31:0]           total_angle_q;
	motor_reply_t          expected_replies[$];

	// Applies one received frame to the motor state and returns the reply it should produce.
	function automatic motor_reply_t predict_reply(input logic [FRAME_ID_W-1:0] id,
		input logic [PAYLOAD_W-1:0] pl);
		logic [7:0]       code;
		logic [ENC_W-1:0] enc;
		longint           step;
		motor_reply_t     r;
		code = pl[7:0];
		if (id == own_frame_id) begin
			if (code == CMD_STATUS2 || (code >= CMD_CLOSED_1 && code <= CMD_CLOSED_8)) begin
				temp_q = pl[15:8];
				current_q = pl[31:16];
				speed_q = pl[47:32];
				enc = pl[63:48];
				if (!tracking_on) begin
					tracking_on = 1'b1;
				end else begin
					step = longint'($signed(enc)) - longint'($signed(prev_position));
					if (step > COUNTS_PER_TURN / 2) begin
						turn_count = turn_count - 1'b1;
						step = step - COUNTS_PER_TURN;
					end else if (step < -(COUNTS_PER_TURN / 2)) begin
						turn_count = turn_count + 1'b1;
						step = step + COUNTS_PER_TURN;
					end
					angle_counts = angle_counts + step[ACC_W-1:0];
				end
				prev_position = enc;
			end else if (code == CMD_STATUS1_A || code == CMD_STATUS1_B) begin
				temp_q = pl[15:8];
				voltage_q = pl[39:24];
				error_q = pl[63:56];
			end else if (code == CMD_TOTAL_ANGLE) begin
				total_angle_q = pl[39:8];
			end else if (code == CMD_ACCEL_A || code == CMD_ACCEL_B) begin
				accel_q = pl[63:32];
			end
		end
		r = '0;
		r.accepted = (id == own_frame_id);
		r.command_code = code;
		r.temperature = temp_q;
		r.torque_current = current_q;
		r.speed_raw = speed_q;
		r.encoder_value = prev_position;
		r.round_count = turn_count;
		r.total_counts = angle_counts;
		r.error_flags = error_q;
		r.bus_voltage = voltage_q;
		r.accel_value = accel_q;
		r.reported_total_angle = total_angle_q;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			report_mismatch($sformatf("%s expected %h, got %h", name, want, got));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		motor_reply_t want;
		motor_reply_t got;
		if (!arst_n) begin
			own_frame_id = OWN_FRAME_ID_RST;
			tracking_on = 1'b0;
			prev_position = '0;
			turn_count = '0;
			angle_counts = '0;
			temp_q = '0;
			error_q = '0;
			current_q = '0;
			speed_q = '0;
			voltage_q = '0;
			accel_q = '0;
			total_angle_q = '0;
			expected_replies.delete();
		end else begin
			if (cfg_wr_en) begin
				own_frame_id = cfg_wr_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_replies.push_back(predict_reply(s_axis_tdata[FRAME_ID_W-1:0],
					s_axis_tdata[FRAME_ID_W +: PAYLOAD_W]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_replies.size() == 0) begin
					report_mismatch($sformatf("reply with no request pending: %h", m_axis_tdata));
				end else begin
					want = expected_replies.pop_front();
					check_field("accepted", 64'(want.accepted), 64'(got.accepted));
					check_field("command_code", 64'(want.command_code), 64'(got.command_code));
					check_field("temperature", 64'(want.temperature), 64'(got.temperature));
					check_field("torque_current", 64'(want.torque_current),
						64'(got.torque_current));
					check_field("speed_raw", 64'(want.speed_raw), 64'(got.speed_raw));
					check_field("encoder_value", 64'(want.encoder_value), 64'(got.encoder_value));
					check_field("round_count", 64'(want.round_count), 64'(got.round_count));
					check_field("total_counts", 64'(want.total_counts), 64'(got.total_counts));
					check_field("error_flags", 64'(want.error_flags), 64'(got.error_flags));
					check_field("bus_voltage", 64'(want.bus_voltage), 64'(got.bus_voltage));
					check_field("accel_value", 64'(want.accel_value), 64'(got.accel_value));
					check_field("reported_total_angle", 64'(want.reported_total_angle),
						64'(got.reported_total_angle));
				end
			end
		end
		pending = expected_replies.size();
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Top of the motor reply decoder testbench: clock, reset, request stimulus and verdict.
module tb;
	import mrd_pkg::*;

	localparam logic [7:0] CMD_UNKNOWN_LO = 8'h00;
	localparam logic [7:0] CMD_UNKNOWN_HI = 8'hFF;
	localparam int PHASE_REQUESTS = 295;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [FRAME_ID_W-1:0] cfg_wr_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	int                    fail_count;
	int                    pending;

	int                    sender_idle_pct = 0;
	int                    receiver_stall_pct = 0;
	logic [FRAME_ID_W-1:0] own_id;
	logic [ENC_W-1:0]      last_enc;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	motor_reply_decoder_multiturn dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	motor_reply_compare reply_compare (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Codes 0 to 8 are the motion replies, 9 to 13 the other stored replies.
	function automatic logic [7:0] pick_code(input int sel);
		case (sel)
			0: return CMD_STATUS2;
			1: return CMD_CLOSED_1;
			2: return CMD_CLOSED_2;
			3: return CMD_CLOSED_3;
			4: return CMD_CLOSED_4;
			5: return CMD_CLOSED_5;
			6: return CMD_CLOSED_6;
			7: return CMD_CLOSED_7;
			8: return CMD_CLOSED_8;
			9: return CMD_STATUS1_A;
			10: return CMD_STATUS1_B;
			11: return CMD_TOTAL_ANGLE;
			12: return CMD_ACCEL_A;
			default: return CMD_ACCEL_B;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken,
	// with tvalid still high so that a following request can go out without a gap.
	task automatic send_request(input logic [FRAME_ID_W-1:0] id,
		input logic [PAYLOAD_W-1:0] pl);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(S_TDATA_W - FRAME_ID_W - PAYLOAD_W){1'b0}}, pl, id};
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_frame_id(input logic [FRAME_ID_W-1:0] id);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= id;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		own_id = id;
	endtask

	task automatic run_phase(input logic [FRAME_ID_W-1:0] id, input int idle, input int stall);
		logic [FRAME_ID_W-1:0] frame_id;
		logic [PAYLOAD_W-1:0]  pl;
		logic [ENC_W-1:0]      enc;
		int                    kind;
		write_frame_id(id);
		sender_idle_pct = idle;
		receiver_stall_pct = stall;
		repeat (PHASE_REQUESTS) begin
			frame_id = ($urandom_range(99) < 85) ? own_id : FRAME_ID_W'($urandom);
			pl = {$urandom, $urandom};
			kind = $urandom_range(99);
			if (kind < 55) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4: enc = last_enc + ENC_W'($urandom_range(4000)) - 16'd2000;
					5, 6: enc = last_enc + 16'h8000 + ENC_W'($urandom_range(8)) - 16'd4;
					7: enc = ENC_W'($urandom);
					8: begin
						case ($urandom_range(3))
							0: enc = 16'h7FFF;
							1: enc = 16'h8000;
							2: enc = 16'h0000;
							default: enc = 16'hFFFF;
						endcase
					end
					default: enc = last_enc;
				endcase
				last_enc = enc;
				pl = {enc, pl[47:8], pick_code($urandom_range(8))};
			end else if (kind < 85) begin
				pl[7:0] = pick_code($urandom_range(13, 9));
			end
			send_request(frame_id, pl);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		own_id = OWN_FRAME_ID_RST;
		last_enc = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A frame for another motor must leave everything untouched.
		send_request(11'd0, {16'h1234, 40'hFF_FFFF_FFFF, CMD_STATUS2});
		// The first motion reply only seeds tracking; then the half-turn boundaries.
		send_request(own_id, {16'h7FFF, 16'hFFFF, 16'hFFFF, 8'hFF, CMD_STATUS2});
		send_request(own_id, {16'h8000, 16'h8000, 16'h8000, 8'h00, CMD_STATUS2});
		send_request(own_id, {16'h0000, 16'h7FFF, 16'h7FFF, 8'h80, CMD_STATUS2});
		send_request(own_id, {16'h8000, 16'h0000, 16'h0000, 8'h01, CMD_STATUS2});
		send_request(own_id, {16'h0001, 16'hFFFF, 16'h0001, 8'hFE, CMD_STATUS2});
		for (int k = 1; k <= 8; k++) begin
			send_request(own_id, {16'(k * 24576), 16'h8000, 16'h7FFF, 8'(k), pick_code(k)});
		end
		send_request(own_id, {56'hFF_FFFF_FFFF_FFFF, CMD_STATUS1_A});
		send_request(own_id, {56'h0, CMD_STATUS1_B});
		send_request(own_id, {24'hFF_FFFF, 32'h8000_0001, CMD_TOTAL_ANGLE});
		send_request(own_id, {32'h8000_0000, 24'hFF_FFFF, CMD_ACCEL_A});
		send_request(own_id, {32'h7FFF_FFFF, 24'h0, CMD_ACCEL_B});
		send_request(own_id, {56'hFF_FFFF_FFFF_FFFF, CMD_UNKNOWN_LO});
		send_request(own_id, {56'h0, CMD_UNKNOWN_HI});
		send_request(11'h7FF, {56'hFF_FFFF_FFFF_FFFF, CMD_STATUS1_A});

		run_phase(11'd0, 0, 0);
		run_phase(11'h7FF, 80, 0);
		run_phase(FRAME_ID_W'($urandom), 0, 80);
		run_phase(OWN_FRAME_ID_RST, 28, 28);

		wait_drained();
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
